/* rtl/dtp_pkg.sv */
// Package for the date-time text parser: pattern constants, the expected
// character class per position, result types and the decimal fold helpers.
// No dependencies.
`default_nettype none

package dtp_pkg;

  localparam int unsigned POS_W    = 5;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned TWO_W    = 7;
  localparam int unsigned WDAY_W   = 4;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [POS_W-1:0] FULL_LEN   = 5'd21;
  localparam logic [CH_W-1:0]  CH_END     = 8'd0;
  localparam logic [CH_W-1:0]  CH_ZERO    = 8'd48;
  localparam logic [CH_W-1:0]  CH_NINE    = 8'd57;
  localparam logic [CH_W-1:0]  CH_DASH    = 8'd45;
  localparam logic [CH_W-1:0]  CH_COLON   = 8'd58;

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_DASH,
    KIND_COLON
  } kind_e;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [TWO_W-1:0]  month;
    logic [TWO_W-1:0]  day;
    logic [WDAY_W-1:0] weekday;
    logic [TWO_W-1:0]  hour;
    logic [TWO_W-1:0]  minute;
    logic [TWO_W-1:0]  second;
  } fields_t;

  typedef struct packed {
    logic    matched;
    fields_t f;
  } result_t;

  // Character class expected at each position of YYYY-MM-DD-W-HH:MM:SS.
  function automatic kind_e expect_kind(input logic [POS_W-1:0] pos);
    kind_e k;
    case (pos)
      5'd4, 5'd7, 5'd10, 5'd12: k = KIND_DASH;
      5'd15, 5'd18:             k = KIND_COLON;
      default:                  k = KIND_DIGIT;
    endcase
    return k;
  endfunction

  // acc * 10 + d, kept to 7 bits, built from shifts.
  function automatic logic [TWO_W-1:0] fold7(input logic [TWO_W-1:0] acc,
                                             input logic [DIGIT_W-1:0] d);
    logic [TWO_W+2:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(TWO_W-1){1'b0}}, d};
    return t[TWO_W-1:0];
  endfunction

  // acc * 10 + d, kept to 14 bits.
  function automatic logic [YEAR_W-1:0] fold14(input logic [YEAR_W-1:0] acc,
                                               input logic [DIGIT_W-1:0] d);
    logic [YEAR_W+2:0] t;
    t = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{(YEAR_W-1){1'b0}}, d};
    return t[YEAR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/dtp_in_if.sv */
// Character channel of the date-time text parser: valid, ready and one byte.
// Depends on dtp_pkg for the character width.
`default_nettype none

interface dtp_in_if;
  logic                      valid;
  logic                      ready;
  logic [dtp_pkg::CH_W-1:0]  ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

`default_nettype wire

/* rtl/dtp_out_if.sv */
// Result channel of the date-time text parser: valid, ready and the decoded
// fields. Depends on dtp_pkg for the field widths.
`default_nettype none

interface dtp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        matched;
  logic [dtp_pkg::YEAR_W-1:0]  year;
  logic [dtp_pkg::TWO_W-1:0]   month;
  logic [dtp_pkg::TWO_W-1:0]   day;
  logic [dtp_pkg::WDAY_W-1:0]  weekday;
  logic [dtp_pkg::TWO_W-1:0]   hour;
  logic [dtp_pkg::TWO_W-1:0]   minute;
  logic [dtp_pkg::TWO_W-1:0]   second;

  modport source (output valid, output matched, output year, output month,
                  output day, output weekday, output hour, output minute,
                  output second, input ready);
  modport sink   (input valid, input matched, input year, input month,
                  input day, input weekday, input hour, input minute,
                  input second, output ready);
endinterface

`default_nettype wire

/* rtl/datetime_text_parser.sv */
// Date-time text parser: matches YYYY-MM-DD-W-HH:MM:SS one character a cycle.
// Throughput: one character per cycle, a class compare and a multiply-by-ten accumulate;
// the character channel stalls only while both result slots are full.
// A zero byte's result shows on out_o in the next cycle when out_o is free or taken
// that cycle; otherwise the result waits in the skid slot behind the held one.
// Reset (rst_ni low, asynchronous) clears position, accumulators and both valid flags.
`default_nettype none

module datetime_text_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dtp_in_if.sink     in_i,
  dtp_out_if.source  out_o
);

  // Parser state. The position counter names the next pattern position;
  // once it reaches the full length every further character is ignored
  // until the terminating zero byte.
  logic [dtp_pkg::POS_W-1:0] pos_q, pos_d;
  dtp_pkg::fields_t          acc_q, acc_d;

  // Result register plus one skid slot, so that a finished result waiting
  // on the sink does not stop characters from flowing in.
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  dtp_pkg::result_t out_q, out_d;
  dtp_pkg::result_t skid_q, skid_d;

  logic             in_take;
  logic             is_end;
  logic             is_digit;
  logic             hit;
  logic             push;
  logic             pop;
  dtp_pkg::kind_e   kind;
  logic [dtp_pkg::DIGIT_W-1:0] digit;
  logic [dtp_pkg::CH_W-1:0]    digit_wide;
  dtp_pkg::result_t res_new;

  // Characters are accepted whenever the skid slot is free: a zero byte
  // then always has somewhere to land its result.
  assign in_i.ready = ~skid_valid_q;
  assign in_take    = in_i.valid & in_i.ready;
  assign is_end     = (in_i.ch == dtp_pkg::CH_END);

  assign kind       = dtp_pkg::expect_kind(pos_q);
  assign is_digit   = (in_i.ch >= dtp_pkg::CH_ZERO) && (in_i.ch <= dtp_pkg::CH_NINE);
  assign digit_wide = in_i.ch - dtp_pkg::CH_ZERO;
  assign digit      = digit_wide[dtp_pkg::DIGIT_W-1:0];

  always_comb begin
    case (kind)
      dtp_pkg::KIND_DIGIT: hit = is_digit;
      dtp_pkg::KIND_DASH:  hit = (in_i.ch == dtp_pkg::CH_DASH);
      dtp_pkg::KIND_COLON: hit = (in_i.ch == dtp_pkg::CH_COLON);
      default:             hit = 1'b0;
    endcase
  end

  // The result formed by a zero byte: the accumulated fields if the whole
  // pattern has been seen, otherwise all zeros.
  always_comb begin
    res_new = '0;
    if (pos_q == dtp_pkg::FULL_LEN) begin
      res_new.matched = 1'b1;
      res_new.f       = acc_q;
    end
  end

  // Next parser state. The first digit of each field loads its accumulator,
  // so values left over from an earlier partial match never leak through.
  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (in_take) begin
      if (is_end) begin
        pos_d = '0;
        acc_d = '0;
      end else if (pos_q < dtp_pkg::FULL_LEN) begin
        if (hit) begin
          pos_d = pos_q + 5'd1;
          if (kind == dtp_pkg::KIND_DIGIT) begin
            case (pos_q) inside
              5'd0:             acc_d.year = {{(dtp_pkg::YEAR_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              [5'd1:5'd3]:      acc_d.year = dtp_pkg::fold14(acc_q.year, digit);
              5'd5:             acc_d.month = {{(dtp_pkg::TWO_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              5'd6:             acc_d.month = dtp_pkg::fold7(acc_q.month, digit);
              5'd8:             acc_d.day = {{(dtp_pkg::TWO_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              5'd9:             acc_d.day = dtp_pkg::fold7(acc_q.day, digit);
              5'd11:            acc_d.weekday = digit;
              5'd13:            acc_d.hour = {{(dtp_pkg::TWO_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              5'd14:            acc_d.hour = dtp_pkg::fold7(acc_q.hour, digit);
              5'd16:            acc_d.minute = {{(dtp_pkg::TWO_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              5'd17:            acc_d.minute = dtp_pkg::fold7(acc_q.minute, digit);
              5'd19:            acc_d.second = {{(dtp_pkg::TWO_W-dtp_pkg::DIGIT_W){1'b0}}, digit};
              5'd20:            acc_d.second = dtp_pkg::fold7(acc_q.second, digit);
              default:          acc_d = acc_q;
            endcase
          end
        end else begin
          // A mismatch restarts the pattern; the character itself is dropped.
          pos_d = '0;
        end
      end
    end
  end

  // Result register and skid slot. The skid slot fills only when a new result
  // arrives while the output register is held by the sink.
  assign push = in_take & is_end;
  assign pop  = out_valid_q & out_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else if (push) begin
        out_d       = res_new;
        out_valid_d = 1'b1;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (push) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      acc_q        <= acc_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Result payload carries no reset; it is only looked at while valid.
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = out_q.matched;
  assign out_o.year    = out_q.f.year;
  assign out_o.month   = out_q.f.month;
  assign out_o.day     = out_q.f.day;
  assign out_o.weekday = out_q.f.weekday;
  assign out_o.hour    = out_q.f.hour;
  assign out_o.minute  = out_q.f.minute;
  assign out_o.second  = out_q.f.second;

endmodule

`default_nettype wire

/* rtl/dtp_checker.sv */
// Port-level checks for the date-time text parser, bound to its top level.
// Depends on dtp_pkg for widths.
`default_nettype none

module dtp_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [dtp_pkg::CH_W-1:0]    in_ch_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_matched_i,
  input wire logic [dtp_pkg::YEAR_W-1:0]  out_year_i,
  input wire logic [dtp_pkg::TWO_W-1:0]   out_month_i,
  input wire logic [dtp_pkg::TWO_W-1:0]   out_day_i,
  input wire logic [dtp_pkg::WDAY_W-1:0]  out_weekday_i,
  input wire logic [dtp_pkg::TWO_W-1:0]   out_hour_i,
  input wire logic [dtp_pkg::TWO_W-1:0]   out_minute_i,
  input wire logic [dtp_pkg::TWO_W-1:0]   out_second_i
);

  // A stalled result transaction keeps its valid and its match flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_matched_i))
    else $error("result changed while stalled");

  // After a terminating zero byte is taken, a result is always valid in the next cycle.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_ch_i == dtp_pkg::CH_END) |=> out_valid_i)
    else $error("zero byte produced no result");

  // An ordinary character into an empty block produces nothing.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_ch_i != dtp_pkg::CH_END) && !out_valid_i
    |=> !out_valid_i)
    else $error("result appeared without a zero byte");

  // Unmatched results are all zero; matched ones hold decimal digit values.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      (out_matched_i ?
        (out_year_i <= 14'd9999 && out_month_i <= 7'd99 && out_day_i <= 7'd99 &&
         out_weekday_i <= 4'd9 && out_hour_i <= 7'd99 && out_minute_i <= 7'd99 &&
         out_second_i <= 7'd99) :
        (out_year_i == '0 && out_month_i == '0 && out_day_i == '0 &&
         out_weekday_i == '0 && out_hour_i == '0 && out_minute_i == '0 &&
         out_second_i == '0)))
    else $error("result fields out of range");

endmodule

bind datetime_text_parser dtp_checker u_dtp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_ch_i       (in_i.ch),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_matched_i (out_o.matched),
  .out_year_i    (out_o.year),
  .out_month_i   (out_o.month),
  .out_day_i     (out_o.day),
  .out_weekday_i (out_o.weekday),
  .out_hour_i    (out_o.hour),
  .out_minute_i  (out_o.minute),
  .out_second_i  (out_o.second)
);

`default_nettype wire

/* sim/datetime_text_parser_tb.sv */
// Self-checking testbench for the date-time text parser (datetime_text_parser).
// Depends on dtp_pkg, dtp_in_if and dtp_out_if from the RTL; drives characters in,
// predicts each decoded date stamp and compares every field of every result.
`default_nettype none

module datetime_text_parser_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned MAX_GAP      = 11;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;

  // How the digit positions of a generated date are filled.
  typedef enum int {FILL_RANDOM, FILL_ZEROS, FILL_NINES} fill_e;

  // Shapes of generated strings; every string ends with the zero byte.
  typedef enum int {LINE_DATE, LINE_BROKEN, LINE_RESTART, LINE_SHORT, LINE_NOISE} line_e;

  // The tracker follows the parser character by character: it keeps its own
  // pattern position and field accumulators, and queues the date stamp that
  // each zero byte must produce. Results are checked against the queue in order.
  class datetime_tracker;
    logic [dtp_pkg::POS_W-1:0] pos;
    dtp_pkg::fields_t          acc;
    dtp_pkg::result_t          stamps_due[$];
    int                        errors;

    function new();
      pos    = '0;
      acc    = '0;
      errors = 0;
    endfunction

    // Character class wanted at each place of YYYY-MM-DD-W-HH:MM:SS.
    static function dtp_pkg::kind_e kind_at(int p);
      if (p == 15 || p == 18) return dtp_pkg::KIND_COLON;
      if (p == 4 || p == 7 || p == 10 || p == 12) return dtp_pkg::KIND_DASH;
      return dtp_pkg::KIND_DIGIT;
    endfunction

    // Folds one accepted character into the state. Returns 0 only when the
    // character is ignored because the whole pattern has already been seen.
    function bit take_char(logic [dtp_pkg::CH_W-1:0] c);
      dtp_pkg::result_t            stamp;
      logic [dtp_pkg::DIGIT_W-1:0] d;
      dtp_pkg::kind_e              k;
      bit                          hit;
      if (c == dtp_pkg::CH_END) begin
        stamp.matched = (pos == dtp_pkg::FULL_LEN);
        stamp.f       = stamp.matched ? acc : '0;
        stamps_due.push_back(stamp);
        pos = '0;
        acc = '0;
        return 1'b1;
      end
      if (pos >= dtp_pkg::FULL_LEN) return 1'b0;
      k = kind_at(int'(pos));
      case (k)
        dtp_pkg::KIND_DIGIT: hit = (c >= dtp_pkg::CH_ZERO) && (c <= dtp_pkg::CH_NINE);
        dtp_pkg::KIND_DASH:  hit = (c == dtp_pkg::CH_DASH);
        default:             hit = (c == dtp_pkg::CH_COLON);
      endcase
      if (!hit) begin
        pos = '0;
        return 1'b1;
      end
      if (k == dtp_pkg::KIND_DIGIT) begin
        d = dtp_pkg::DIGIT_W'(c - dtp_pkg::CH_ZERO);
        // The first digit of a field loads it, later digits shift it up by ten.
        case (int'(pos))
          0:       acc.year    = dtp_pkg::YEAR_W'(d);
          1, 2, 3: acc.year    = dtp_pkg::YEAR_W'(acc.year * 10 + d);
          5:       acc.month   = dtp_pkg::TWO_W'(d);
          6:       acc.month   = dtp_pkg::TWO_W'(acc.month * 10 + d);
          8:       acc.day     = dtp_pkg::TWO_W'(d);
          9:       acc.day     = dtp_pkg::TWO_W'(acc.day * 10 + d);
          11:      acc.weekday = d;
          13:      acc.hour    = dtp_pkg::TWO_W'(d);
          14:      acc.hour    = dtp_pkg::TWO_W'(acc.hour * 10 + d);
          16:      acc.minute  = dtp_pkg::TWO_W'(d);
          17:      acc.minute  = dtp_pkg::TWO_W'(acc.minute * 10 + d);
          19:      acc.second  = dtp_pkg::TWO_W'(d);
          20:      acc.second  = dtp_pkg::TWO_W'(acc.second * 10 + d);
          default: ;
        endcase
      end
      pos = pos + 1'b1;
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_stamp(dtp_pkg::result_t got);
      dtp_pkg::result_t want;
      if (stamps_due.size() == 0) begin
        $error("result with no zero byte outstanding: matched %0d year %0d",
               got.matched, got.f.year);
        errors++;
        return;
      end
      want = stamps_due.pop_front();
      compare_field("matched", want.matched,   got.matched);
      compare_field("year",    want.f.year,    got.f.year);
      compare_field("month",   want.f.month,   got.f.month);
      compare_field("day",     want.f.day,     got.f.day);
      compare_field("weekday", want.f.weekday, got.f.weekday);
      compare_field("hour",    want.f.hour,    got.f.hour);
      compare_field("minute",  want.f.minute,  got.f.minute);
      compare_field("second",  want.f.second,  got.f.second);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dtp_in_if  char_ch ();
  dtp_out_if stamp_ch ();

  datetime_text_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (stamp_ch)
  );

  datetime_tracker tracker = new();

  // Upper bounds of the per-transaction idle draws; the stimulus changes them
  // from time to time so that busy stretches alternate with sparse ones.
  int unsigned send_gap_max = MAX_GAP;
  int unsigned take_gap_max = MAX_GAP;
  // Set by the stimulus to make the result side hold off for a long while.
  bit          hold_request = 1'b0;
  int unsigned counted      = 0;
  int unsigned cycle_count  = 0;
  logic [dtp_pkg::CH_W-1:0] line_q[$];

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake must not leave the simulation running for ever.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(3))
      0:       return 0;
      1:       return MAX_GAP;
      default: return $urandom_range(MAX_GAP);
    endcase
  endfunction

  // Appends the first 'upto' places of a well-formed date to the line buffer.
  function automatic void add_date(fill_e fill, int unsigned upto);
    for (int p = 0; p < int'(upto); p++) begin
      case (datetime_tracker::kind_at(p))
        dtp_pkg::KIND_DIGIT: begin
          case (fill)
            FILL_ZEROS: line_q.push_back(dtp_pkg::CH_ZERO);
            FILL_NINES: line_q.push_back(dtp_pkg::CH_NINE);
            default:    line_q.push_back(dtp_pkg::CH_ZERO +
                                         dtp_pkg::CH_W'($urandom_range(9)));
          endcase
        end
        dtp_pkg::KIND_DASH: line_q.push_back(dtp_pkg::CH_DASH);
        default:            line_q.push_back(dtp_pkg::CH_COLON);
      endcase
    end
  endfunction

  // Any nonzero byte, so every bit of the character sees both values.
  function automatic void add_noise(int unsigned n);
    repeat (n) line_q.push_back(dtp_pkg::CH_W'($urandom_range(255, 1)));
  endfunction

  function automatic void build_line(line_e shape);
    int unsigned sel;
    int unsigned spot;
    fill_e       fill;
    sel  = $urandom_range(9);
    fill = (sel == 0) ? FILL_ZEROS : (sel == 1) ? FILL_NINES : FILL_RANDOM;
    case (shape)
      LINE_DATE: begin
        add_date(fill, 21);
        // Trailing characters after a full match must be ignored.
        if ($urandom_range(2) == 0) add_noise($urandom_range(3, 1));
      end
      LINE_BROKEN: begin
        add_date(fill, 21);
        spot = $urandom_range(20);
        line_q[spot] = dtp_pkg::CH_W'($urandom_range(255, 1));
      end
      LINE_RESTART: begin
        // A partial date leaves values in the accumulators; a following full
        // date must load fresh fields rather than build on the stale ones.
        add_date(FILL_RANDOM, $urandom_range(20, 1));
        if ($urandom_range(3) != 0) begin
          line_q.push_back(dtp_pkg::CH_W'($urandom_range(255, 59)));
        end
        add_date(fill, 21);
      end
      LINE_SHORT: add_date(fill, $urandom_range(20));
      default:    add_noise($urandom_range(30));
    endcase
    line_q.push_back(dtp_pkg::CH_END);
  endfunction

  // One character transaction. Valid stays high across back-to-back
  // transactions and is only dropped when an idle gap is drawn.
  task automatic send_char(logic [dtp_pkg::CH_W-1:0] c);
    int unsigned gap;
    gap = $urandom_range(send_gap_max);
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_ch.valid <= 1'b1;
    char_ch.ch    <= c;
    do @(posedge clk_i); while (!char_ch.ready);
    if (tracker.take_char(c)) counted++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_char(line_q[i]);
    line_q.delete();
  endtask

  // Result side: draws an idle gap before each transaction, or a long hold-off
  // when asked, then checks whatever result is accepted.
  initial begin
    int unsigned      gap;
    dtp_pkg::result_t got;
    stamp_ch.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = $urandom_range(take_gap_max);
      end
      if (gap > 0) begin
        stamp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      stamp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!stamp_ch.valid);
      got.matched   = stamp_ch.matched;
      got.f.year    = stamp_ch.year;
      got.f.month   = stamp_ch.month;
      got.f.day     = stamp_ch.day;
      got.f.weekday = stamp_ch.weekday;
      got.f.hour    = stamp_ch.hour;
      got.f.minute  = stamp_ch.minute;
      got.f.second  = stamp_ch.second;
      tracker.check_stamp(got);
    end
  end

  initial begin
    int unsigned pick;
    bit          pressed;
    line_e       shape;
    pressed        = 1'b0;
    rst_ni         = 1'b0;
    char_ch.valid <= 1'b0;
    char_ch.ch    <= dtp_pkg::CH_END;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: a stray character just below the digits at the first
    // place, the largest value in every field, a character just above the colon
    // after the full pattern (ignored), its terminator, and then an empty string.
    line_q.push_back(dtp_pkg::CH_ZERO - 8'd1);
    add_date(FILL_NINES, 21);
    line_q.push_back(dtp_pkg::CH_COLON + 8'd1);
    line_q.push_back(dtp_pkg::CH_END);
    line_q.push_back(dtp_pkg::CH_END);
    send_line();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        send_gap_max = pick_gap_max();
        take_gap_max = pick_gap_max();
      end
      if (!pressed && counted >= RANDOM_ITEMS / 2) begin
        // Back-pressure: the result side holds off for a long stretch while
        // characters keep coming at full rate, so the result slots fill and
        // the character channel has to stall.
        pressed      = 1'b1;
        hold_request = 1'b1;
        send_gap_max = 0;
        repeat (40) begin
          if ($urandom_range(1) == 0) line_q.push_back(dtp_pkg::CH_END);
          else build_line(LINE_DATE);
        end
        send_line();
      end
      pick = $urandom_range(99);
      if (pick < 55)      shape = LINE_DATE;
      else if (pick < 67) shape = LINE_BROKEN;
      else if (pick < 77) shape = LINE_RESTART;
      else if (pick < 87) shape = LINE_SHORT;
      else                shape = LINE_NOISE;
      build_line(shape);
      send_line();
    end
    char_ch.valid <= 1'b0;

    // Wait for the last results, then a little longer to catch any stray one.
    while (tracker.stamps_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/dtp_pkg.sv
rtl/dtp_in_if.sv
rtl/dtp_out_if.sv
rtl/datetime_text_parser.sv
rtl/dtp_checker.sv
sim/datetime_text_parser_tb.sv
